[hw/rtl/kbrt_pkg.sv]
// Package for the k-bucket routing table: widths, codes and defaults.
// No dependencies.
`timescale 1ns / 1ps
package kbrt_pkg;
    localparam int DEF_ADDRESS_BITS = 40;
    localparam int DEF_BUCKET_DEPTH = 8;
    localparam int EP_W             = 48;
    localparam int TS_W             = 32;
    localparam int PING_W           = 8;
    localparam int KIND_W           = 2;
    localparam int STATUS_W         = 3;
    localparam int BIDX_W           = 6;
    localparam int CFG_IDX_W        = 2;
    localparam int ABITS_W          = 6;
    localparam int LIMIT_W          = 4;

    localparam logic [KIND_W-1:0] KIND_SEEN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PONG  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ABITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;
endpackage

[hw/rtl/kbrt_ifs.sv]
// Channel interfaces: item, result and config write words.
// Depends on kbrt_pkg.
`timescale 1ns / 1ps
interface kbrt_item_if import kbrt_pkg::*; #(parameter int AW = DEF_ADDRESS_BITS);
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [AW-1:0]     node_address;
    logic [EP_W-1:0]   node_endpoint;
    logic [TS_W-1:0]   timestamp;
    modport source (output valid, kind, node_address, node_endpoint, timestamp, input ready);
    modport sink   (input valid, kind, node_address, node_endpoint, timestamp, output ready);
endinterface

interface kbrt_result_if import kbrt_pkg::*; #(parameter int AW = DEF_ADDRESS_BITS);
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [AW-1:0]       entry_address;
    logic [EP_W-1:0]     entry_endpoint;
    logic [BIDX_W-1:0]   bucket_index;
    logic                last_result;
    modport source (output valid, status, entry_address, entry_endpoint, bucket_index,
                    last_result, input ready);
    modport sink   (input valid, status, entry_address, entry_endpoint, bucket_index,
                    last_result, output ready);
endinterface

interface kbrt_cfg_if import kbrt_pkg::*; #(parameter int AW = DEF_ADDRESS_BITS);
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [AW-1:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/kbrt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module kbrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[hw/rtl/kbrt_ctrl.sv]
// Item sequencer: bucket lookup, bucket scan, insert/refresh, closest walk.
// Depends on kbrt_pkg, kbrt_ifs; drives the entry and fill count RAMs.
`timescale 1ns / 1ps
module kbrt_ctrl import kbrt_pkg::*; #(
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
    parameter int BUCKET_DEPTH = DEF_BUCKET_DEPTH,
    localparam int BW = $clog2(ADDRESS_BITS),
    localparam int EW = $clog2(ADDRESS_BITS * BUCKET_DEPTH),
    localparam int CW = $clog2(BUCKET_DEPTH + 1),
    localparam int WW = ADDRESS_BITS + EP_W + TS_W + PING_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    kbrt_item_if.sink               in_ch,
    kbrt_result_if.source           out_ch,
    input  logic [ADDRESS_BITS-1:0] own_id,
    input  logic [ABITS_W-1:0]      act_bits,
    input  logic [CW-1:0]           lim,
    output logic                    ent_we,
    output logic [EW-1:0]           ent_waddr,
    output logic [WW-1:0]           ent_wdata,
    output logic                    ent_re,
    output logic [EW-1:0]           ent_raddr,
    input  logic [WW-1:0]           ent_rdata,
    output logic                    cnt_we,
    output logic [BW-1:0]           cnt_waddr,
    output logic [CW-1:0]           cnt_wdata,
    output logic                    cnt_re,
    output logic [BW-1:0]           cnt_raddr,
    input  logic [CW-1:0]           cnt_rdata
);
    localparam int AW = ADDRESS_BITS;
    localparam int SW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam logic [EW-1:0] DEPTH_E = EW'(BUCKET_DEPTH);
    localparam logic [BW-1:0] TOP_B   = BW'(ADDRESS_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIST, S_CNT, S_RD, S_CMP, S_QWAIT, S_QRD, S_QCMP, S_QNEXT, S_QEND, S_EMIT
    } state_t;

    state_t              state_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [AW-1:0]       addr_reg;
    logic [EP_W-1:0]     ep_reg;
    logic [TS_W-1:0]     ts_reg;
    logic [BW-1:0]       bucket_reg;
    logic [BW-1:0]       cur_reg;
    logic                pass_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       slot_reg;
    logic [CW-1:0]       n_reg;
    logic [AW-1:0]       seen_reg [BUCKET_DEPTH];
    logic                pend_v_reg;
    logic [AW-1:0]       pend_addr_reg;
    logic [EP_W-1:0]     pend_ep_reg;
    logic [BW-1:0]       pend_b_reg;
    logic [STATUS_W-1:0] res_st_reg;
    logic [AW-1:0]       res_addr_reg;
    logic [EP_W-1:0]     res_ep_reg;
    logic [BW-1:0]       res_b_reg;
    logic                res_last_reg;
    logic                out_v_reg;
    logic [STATUS_W-1:0] out_st_reg;
    logic [AW-1:0]       out_addr_reg;
    logic [EP_W-1:0]     out_ep_reg;
    logic [BIDX_W-1:0]   out_b_reg;
    logic                out_last_reg;
    logic [AW-1:0]       cvalid_reg;

    logic [AW-1:0]       xor_dist;
    logic [BW-1:0]       enc;
    logic [CW-1:0]       cnt_eff_b;
    logic [CW-1:0]       cnt_eff_c;
    logic [AW-1:0]       rd_addr;
    logic [PING_W-1:0]   rd_ping;
    logic                dup;
    logic                out_free;
    logic                out_load;
    logic                in_acc;

    assign rd_addr = ent_rdata[AW-1:0];
    assign rd_ping = ent_rdata[WW-1 -: PING_W];
    assign cnt_eff_b = cvalid_reg[bucket_reg] ? cnt_rdata : '0;
    assign cnt_eff_c = cvalid_reg[cur_reg] ? cnt_rdata : '0;
    assign out_free = !out_v_reg || out_ch.ready;
    assign out_load = (state_reg == S_EMIT) && out_free;
    assign in_acc = in_ch.valid && in_ch.ready;

    always_comb
    begin
        xor_dist = '0;
        enc = '0;
        for (int i = 0; i < AW; i++)
        begin
            xor_dist[i] = (addr_reg[i] ^ own_id[i]) && (7'(i) < {1'b0, act_bits});
        end
        for (int i = 0; i < AW; i++)
        begin
            if (xor_dist[i])
            begin
                enc = BW'(i);
            end
        end
    end

    always_comb
    begin
        dup = 1'b0;
        for (int j = 0; j < BUCKET_DEPTH; j++)
        begin
            if ((CW'(j) < n_reg) && (seen_reg[j] == rd_addr))
            begin
                dup = 1'b1;
            end
        end
    end

    always_comb
    begin
        ent_re    = 1'b0;
        ent_raddr = EW'(bucket_reg) * DEPTH_E + EW'(slot_reg);
        ent_we    = 1'b0;
        ent_waddr = EW'(bucket_reg) * DEPTH_E + EW'(slot_reg);
        ent_wdata = {rd_ping, ts_reg, ep_reg, addr_reg};
        cnt_re    = 1'b0;
        cnt_raddr = enc;
        cnt_we    = 1'b0;
        cnt_waddr = bucket_reg;
        cnt_wdata = cnt_reg + CW'(1);
        case (state_reg)
            S_DIST:
            begin
                cnt_re = 1'b1;
            end
            S_RD:
            begin
                if (slot_reg < cnt_reg)
                begin
                    ent_re = 1'b1;
                end
                else if (kind_reg == KIND_SEEN && cnt_reg < lim)
                begin
                    ent_we    = 1'b1;
                    ent_waddr = EW'(bucket_reg) * DEPTH_E + EW'(cnt_reg);
                    ent_wdata = {PING_W'(0), ts_reg, ep_reg, addr_reg};
                    cnt_we    = 1'b1;
                end
            end
            S_CMP:
            begin
                if (rd_addr == addr_reg)
                begin
                    ent_we = 1'b1;
                    if (kind_reg == KIND_PONG)
                    begin
                        ent_wdata = {PING_W'(0), ts_reg, ep_reg, addr_reg};
                    end
                end
            end
            S_QRD:
            begin
                ent_raddr = EW'(cur_reg) * DEPTH_E + EW'(slot_reg);
                if (slot_reg < cnt_reg && n_reg < lim)
                begin
                    ent_re = 1'b1;
                end
            end
            S_QNEXT:
            begin
                cnt_re = 1'b1;
                if (!pass_reg)
                begin
                    cnt_raddr = (cur_reg == '0) ? bucket_reg + BW'(1) : cur_reg - BW'(1);
                end
                else
                begin
                    cnt_raddr = cur_reg + BW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_v_reg    <= 1'b0;
            pend_v_reg   <= 1'b0;
            cvalid_reg   <= '0;
            n_reg        <= '0;
            pass_reg     <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_v_reg <= 1'b0;
            end
            if (cnt_we)
            begin
                cvalid_reg[cnt_waddr] <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && in_ch.kind != KIND_NONE)
                    begin
                        kind_reg   <= in_ch.kind;
                        addr_reg   <= in_ch.node_address;
                        ep_reg     <= in_ch.node_endpoint;
                        ts_reg     <= in_ch.timestamp;
                        n_reg      <= '0;
                        pass_reg   <= 1'b0;
                        pend_v_reg <= 1'b0;
                        state_reg  <= S_DIST;
                    end
                end
                S_DIST:
                begin
                    bucket_reg <= enc;
                    cur_reg    <= enc;
                    state_reg  <= (kind_reg == KIND_QUERY) ? S_QWAIT : S_CNT;
                end
                S_CNT:
                begin
                    cnt_reg   <= cnt_eff_b;
                    slot_reg  <= '0;
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    res_addr_reg <= '0;
                    res_ep_reg   <= '0;
                    res_b_reg    <= bucket_reg;
                    res_last_reg <= 1'b1;
                    if (slot_reg < cnt_reg)
                    begin
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        if (kind_reg == KIND_PONG)
                        begin
                            res_st_reg <= ST_UNKNOWN;
                        end
                        else if (cnt_reg < lim)
                        begin
                            res_st_reg <= ST_INSERTED;
                        end
                        else
                        begin
                            res_st_reg <= ST_DROPPED;
                        end
                        state_reg <= S_EMIT;
                    end
                end
                S_CMP:
                begin
                    if (rd_addr == addr_reg)
                    begin
                        res_st_reg <= ST_UPDATED;
                        state_reg  <= S_EMIT;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + CW'(1);
                        state_reg <= S_RD;
                    end
                end
                S_QWAIT:
                begin
                    cnt_reg   <= cnt_eff_c;
                    slot_reg  <= '0;
                    state_reg <= S_QRD;
                end
                S_QRD:
                begin
                    state_reg <= (slot_reg < cnt_reg && n_reg < lim) ? S_QCMP : S_QNEXT;
                end
                S_QCMP:
                begin
                    slot_reg <= slot_reg + CW'(1);
                    if (!dup)
                    begin
                        seen_reg[SW'(n_reg)] <= rd_addr;
                        n_reg         <= n_reg + CW'(1);
                        pend_v_reg    <= 1'b1;
                        pend_addr_reg <= rd_addr;
                        pend_ep_reg   <= ent_rdata[AW +: EP_W];
                        pend_b_reg    <= cur_reg;
                    end
                    if (!dup && pend_v_reg)
                    begin
                        res_st_reg   <= ST_ENTRY;
                        res_addr_reg <= pend_addr_reg;
                        res_ep_reg   <= pend_ep_reg;
                        res_b_reg    <= pend_b_reg;
                        res_last_reg <= 1'b0;
                        state_reg    <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_QRD;
                    end
                end
                S_QNEXT:
                begin
                    if (n_reg >= lim)
                    begin
                        state_reg <= S_QEND;
                    end
                    else if (!pass_reg)
                    begin
                        if (cur_reg != '0)
                        begin
                            cur_reg   <= cur_reg - BW'(1);
                            state_reg <= S_QWAIT;
                        end
                        else if (bucket_reg == TOP_B)
                        begin
                            state_reg <= S_QEND;
                        end
                        else
                        begin
                            cur_reg   <= bucket_reg + BW'(1);
                            pass_reg  <= 1'b1;
                            state_reg <= S_QWAIT;
                        end
                    end
                    else if (cur_reg == TOP_B)
                    begin
                        state_reg <= S_QEND;
                    end
                    else
                    begin
                        cur_reg   <= cur_reg + BW'(1);
                        state_reg <= S_QWAIT;
                    end
                end
                S_QEND:
                begin
                    res_last_reg <= 1'b1;
                    pend_v_reg   <= 1'b0;
                    if (pend_v_reg)
                    begin
                        res_st_reg   <= ST_ENTRY;
                        res_addr_reg <= pend_addr_reg;
                        res_ep_reg   <= pend_ep_reg;
                        res_b_reg    <= pend_b_reg;
                    end
                    else
                    begin
                        res_st_reg   <= ST_EMPTY;
                        res_addr_reg <= '0;
                        res_ep_reg   <= '0;
                        res_b_reg    <= bucket_reg;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_st_reg   <= res_st_reg;
                        out_addr_reg <= res_addr_reg;
                        out_ep_reg   <= res_ep_reg;
                        out_b_reg    <= BIDX_W'(res_b_reg);
                        out_last_reg <= res_last_reg;
                        state_reg    <= res_last_reg ? S_IDLE : S_QRD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready           = (state_reg == S_IDLE);
    assign out_ch.valid          = out_v_reg;
    assign out_ch.status         = out_st_reg;
    assign out_ch.entry_address  = out_addr_reg;
    assign out_ch.entry_endpoint = out_ep_reg;
    assign out_ch.bucket_index   = out_b_reg;
    assign out_ch.last_result    = out_last_reg;
endmodule

[hw/rtl/xor_kbucket_routing_table_core.sv]
// Top level of the XOR-distance k-bucket routing table: config registers,
// entry and fill count RAMs, sequencer. Depends on kbrt_pkg, kbrt_ifs,
// kbrt_ram, kbrt_ctrl.
`timescale 1ns / 1ps
// One item at a time. Contact-seen and pong items scan s slots in the
// address's bucket, s being at most the bucket depth, and every slot
// needs a read of the entry RAM and a compare.
// A closest query visits buckets one by one, reading the fill count of
// each, then reads and compares its entries and emits each result, and
// stops once the limit of entries is found or the last bucket is passed.
// All entry reads share the one read port of the entry RAM. A new item is
// taken once the last result of the previous one is in the output register.
// No clearing pass: per-bucket valid bits mark fill counts after reset.
module xor_kbucket_routing_table_core import kbrt_pkg::*; #(
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
    parameter int BUCKET_DEPTH = DEF_BUCKET_DEPTH
) (
    input logic           clk,
    input logic           rst_n,
    kbrt_cfg_if.sink      cfg_ch,
    kbrt_item_if.sink     in_ch,
    kbrt_result_if.source out_ch
);
    localparam int BW = $clog2(ADDRESS_BITS);
    localparam int EW = $clog2(ADDRESS_BITS * BUCKET_DEPTH);
    localparam int CW = $clog2(BUCKET_DEPTH + 1);
    localparam int WW = ADDRESS_BITS + EP_W + TS_W + PING_W;

    logic [ADDRESS_BITS-1:0] own_id_reg;
    logic [ABITS_W-1:0]      abits_reg;
    logic [LIMIT_W-1:0]      limit_reg;
    logic [CW-1:0]           lim;

    logic          ent_we, ent_re, cnt_we, cnt_re;
    logic [EW-1:0] ent_waddr, ent_raddr;
    logic [WW-1:0] ent_wdata, ent_rdata;
    logic [BW-1:0] cnt_waddr, cnt_raddr;
    logic [CW-1:0] cnt_wdata, cnt_rdata;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= '0;
            abits_reg  <= ABITS_W'(40);
            limit_reg  <= LIMIT_W'(8);
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_OWN_ID: own_id_reg <= cfg_ch.data;
                REG_ABITS:  abits_reg  <= cfg_ch.data[ABITS_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_ch.data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim = CW'(1);
        end
        else if (5'(limit_reg) > 5'(BUCKET_DEPTH))
        begin
            lim = CW'(BUCKET_DEPTH);
        end
        else
        begin
            lim = CW'(limit_reg);
        end
    end

    kbrt_ram #(.WIDTH(WW), .DEPTH(ADDRESS_BITS * BUCKET_DEPTH)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    kbrt_ram #(.WIDTH(CW), .DEPTH(ADDRESS_BITS)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    kbrt_ctrl #(.ADDRESS_BITS(ADDRESS_BITS), .BUCKET_DEPTH(BUCKET_DEPTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .own_id    (own_id_reg),
        .act_bits  (abits_reg),
        .lim       (lim),
        .ent_we    (ent_we),
        .ent_waddr (ent_waddr),
        .ent_wdata (ent_wdata),
        .ent_re    (ent_re),
        .ent_raddr (ent_raddr),
        .ent_rdata (ent_rdata),
        .cnt_we    (cnt_we),
        .cnt_waddr (cnt_waddr),
        .cnt_wdata (cnt_wdata),
        .cnt_re    (cnt_re),
        .cnt_raddr (cnt_raddr),
        .cnt_rdata (cnt_rdata)
    );
endmodule

[tb/sv/tb_xor_kbucket_routing_table_core.sv]
// Testbench for the XOR k-bucket routing table: drives seen, pong, query and none words,
// predicts every result with a behavioral table model and checks in order.
// Depends on kbrt_pkg, kbrt_ifs and xor_kbucket_routing_table_core.
`timescale 1ns / 1ps
module tb_xor_kbucket_routing_table_core;
    import kbrt_pkg::*;

    localparam int AW = DEF_ADDRESS_BITS;
    localparam int BD = DEF_BUCKET_DEPTH;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [AW-1:0]     addr;
        logic [EP_W-1:0]   ep;
        logic [TS_W-1:0]   ts;
    } contact_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [AW-1:0]       addr;
        logic [EP_W-1:0]     ep;
        logic [BIDX_W-1:0]   bucket;
        logic                last;
    } route_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    kbrt_cfg_if    #(.AW(AW)) cfg_ch ();
    kbrt_item_if   #(.AW(AW)) in_ch ();
    kbrt_result_if #(.AW(AW)) out_ch ();

    xor_kbucket_routing_table_core #(.ADDRESS_BITS(AW), .BUCKET_DEPTH(BD)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // table model
    logic [AW-1:0]   own_id;
    logic [5:0]      abits;
    logic [3:0]      klimit;
    logic [AW-1:0]   tbl_addr [AW*BD];
    logic [EP_W-1:0] tbl_ep   [AW*BD];
    int              fill     [AW];

    contact_word_t pending_words [$];
    route_word_t   expected_routes [$];
    int errors = 0;
    int accepted = 0;

    function automatic int bucket_for(logic [AW-1:0] a);
        logic [AW-1:0] d;
        int bits;
        bits = (abits > AW) ? AW : abits;
        d = a ^ own_id;
        for (int i = AW - 1; i >= 0; i--)
            if (d[i] && i < bits)
                return i;
        return 0;
    endfunction

    function automatic int eff_k();
        if (klimit == 0)
            return 1;
        return (klimit > BD) ? BD : klimit;
    endfunction

    function automatic route_word_t mk(logic [STATUS_W-1:0] st, logic [AW-1:0] a,
                                       logic [EP_W-1:0] ep, int b, logic last);
        route_word_t r;
        r.status = st;
        r.addr = a;
        r.ep = ep;
        r.bucket = b[BIDX_W-1:0];
        r.last = last;
        return r;
    endfunction

    function automatic bit listed(logic [AW-1:0] q [$], logic [AW-1:0] a);
        foreach (q[i])
            if (q[i] == a)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic expect_route(route_word_t r);
        expected_routes.insert(expected_routes.size(), r);
    endtask

    task automatic queue_word(contact_word_t w);
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic predict_routes(contact_word_t w);
        int b;
        int slot;
        int k;
        int n;
        logic [AW-1:0] seen [$];
        route_word_t outs [$];
        b = bucket_for(w.addr);
        k = eff_k();
        slot = -1;
        for (int s = 0; s < fill[b]; s++)
            if (slot < 0 && tbl_addr[b*BD+s] == w.addr)
                slot = b*BD + s;
        if (w.kind == KIND_SEEN) begin
            if (slot >= 0) begin
                tbl_ep[slot] = w.ep;
                expect_route(mk(ST_UPDATED, '0, '0, b, 1'b1));
            end else if (fill[b] < k) begin
                tbl_addr[b*BD+fill[b]] = w.addr;
                tbl_ep[b*BD+fill[b]] = w.ep;
                fill[b]++;
                expect_route(mk(ST_INSERTED, '0, '0, b, 1'b1));
            end else
                expect_route(mk(ST_DROPPED, '0, '0, b, 1'b1));
        end else if (w.kind == KIND_PONG) begin
            if (slot >= 0) begin
                tbl_ep[slot] = w.ep;
                expect_route(mk(ST_UPDATED, '0, '0, b, 1'b1));
            end else
                expect_route(mk(ST_UNKNOWN, '0, '0, b, 1'b1));
        end else if (w.kind == KIND_QUERY) begin
            n = 0;
            for (int c = b; c >= 0 && n < k; c--)
                for (int s = 0; s < fill[c] && n < k; s++)
                    if (!listed(seen, tbl_addr[c*BD+s])) begin
                        seen.insert(seen.size(), tbl_addr[c*BD+s]);
                        outs.insert(outs.size(),
                                    mk(ST_ENTRY, tbl_addr[c*BD+s], tbl_ep[c*BD+s], c, 1'b0));
                        n++;
                    end
            for (int c = b + 1; c < AW && n < k; c++)
                for (int s = 0; s < fill[c] && n < k; s++)
                    if (!listed(seen, tbl_addr[c*BD+s])) begin
                        seen.insert(seen.size(), tbl_addr[c*BD+s]);
                        outs.insert(outs.size(),
                                    mk(ST_ENTRY, tbl_addr[c*BD+s], tbl_ep[c*BD+s], c, 1'b0));
                        n++;
                    end
            if (n == 0)
                expect_route(mk(ST_EMPTY, '0, '0, b, 1'b1));
            else begin
                outs[n-1].last = 1'b1;
                foreach (outs[i])
                    expect_route(outs[i]);
            end
        end
    endtask

    // driver
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.kind <= KIND_SEEN;
            in_ch.node_address <= '0;
            in_ch.node_endpoint <= '0;
            in_ch.timestamp <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            automatic logic busy = in_ch.valid && !in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                predict_routes('{in_ch.kind, in_ch.node_address, in_ch.node_endpoint,
                                 in_ch.timestamp});
                accepted <= accepted + 1;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    automatic contact_word_t w = pending_words.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.kind <= w.kind;
                    in_ch.node_address <= w.addr;
                    in_ch.node_endpoint <= w.ep;
                    in_ch.timestamp <= w.ts;
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else begin
                        burst_left <= $urandom_range(0, 6);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern and monitor
    int stall_phase = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_routes.size() == 0) begin
                    $error("unexpected result word status=%0d", out_ch.status);
                    errors++;
                end else begin
                    automatic route_word_t e = expected_routes.pop_front();
                    if (out_ch.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, out_ch.status); errors++;
                    end
                    if (out_ch.entry_address !== e.addr) begin
                        $error("entry_address exp %h got %h", e.addr, out_ch.entry_address);
                        errors++;
                    end
                    if (out_ch.entry_endpoint !== e.ep) begin
                        $error("entry_endpoint exp %h got %h", e.ep, out_ch.entry_endpoint);
                        errors++;
                    end
                    if (out_ch.bucket_index !== e.bucket) begin
                        $error("bucket_index exp %0d got %0d", e.bucket, out_ch.bucket_index);
                        errors++;
                    end
                    if (out_ch.last_result !== e.last) begin
                        $error("last_result exp %0d got %0d", e.last, out_ch.last_result);
                        errors++;
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 64;
            if (stall_phase < 24)
                out_ch.ready <= 1'b1;
            else if (stall_phase < 44)
                out_ch.ready <= ($urandom_range(0, 2) != 0);
            else
                out_ch.ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // config writes happen only from the initial block, while idle
    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_OWN_ID;
        cfg_ch.data = '0;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [AW-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_OWN_ID)
            own_id = val;
        else if (idx == REG_ABITS)
            abits = val[5:0];
        else
            klimit = val[3:0];
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || in_ch.valid || expected_routes.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic contact_word_t word(logic [KIND_W-1:0] k, logic [AW-1:0] a);
        contact_word_t w;
        w.kind = k;
        w.addr = a;
        w.ep = EP_W'({$urandom, $urandom});
        w.ts = $urandom;
        return w;
    endfunction

    // addresses near own id so buckets fill up and repeat
    function automatic logic [AW-1:0] near_addr();
        logic [AW-1:0] r;
        r = AW'({$urandom, $urandom});
        r = r >> $urandom_range(AW - 7, AW - 1);
        return own_id ^ r;
    endfunction

    task automatic random_phase(int n);
        logic [AW-1:0] known [$];
        logic [AW-1:0] a;
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 19);
            if (known.size() > 0 && sel < 6)
                a = known[$urandom_range(0, known.size() - 1)];
            else if (sel < 16)
                a = near_addr();
            else
                a = AW'({$urandom, $urandom});
            known.insert(known.size(), a);
            sel = $urandom_range(0, 19);
            if (sel < 9)
                queue_word(word(KIND_SEEN, a));
            else if (sel < 13)
                queue_word(word(KIND_PONG, a));
            else if (sel < 19)
                queue_word(word(KIND_QUERY, a));
            else
                queue_word(word(KIND_NONE, a));
        end
        wait_idle();
    endtask

    initial
    begin
        own_id = '0;
        abits = 6'd40;
        klimit = 4'd8;
        foreach (fill[i])
            fill[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty query, extremes, all kinds, full bucket, unknown kind
        queue_word(word(KIND_QUERY, '0));
        queue_word(word(KIND_PONG, {AW{1'b1}}));
        queue_word(word(KIND_SEEN, '0));
        queue_word(word(KIND_SEEN, {AW{1'b1}}));
        queue_word('{KIND_SEEN, {AW{1'b1}}, {EP_W{1'b1}}, {TS_W{1'b1}}});
        queue_word('{KIND_PONG, '0, '0, '0});
        for (int i = 0; i < 10; i++)
            queue_word(word(KIND_SEEN, 40'h80_0000_0000 | AW'(i)));
        queue_word(word(KIND_NONE, 40'h12345));
        queue_word(word(KIND_QUERY, 40'h80_0000_0003));
        queue_word(word(KIND_QUERY, 40'h1));
        wait_idle();

        write_reg(REG_LIMIT, 40'd2);
        write_reg(REG_ABITS, 40'd8);
        write_reg(REG_OWN_ID, 40'hA5_5A5A_A5A5);
        random_phase(30);
        write_reg(REG_LIMIT, 40'd0);
        write_reg(REG_ABITS, 40'd0);
        random_phase(10);
        write_reg(REG_ABITS, 40'd63);
        write_reg(REG_LIMIT, 40'd15);
        write_reg(REG_OWN_ID, {AW{1'b1}});
        random_phase(30);
        write_reg(REG_ABITS, 40'd1);
        write_reg(REG_LIMIT, 40'd1);
        random_phase(10);
        write_reg(REG_ABITS, 40'd40);
        write_reg(REG_LIMIT, 40'd8);
        write_reg(REG_OWN_ID, AW'({$urandom, $urandom}));
        random_phase(35);

        if (errors == 0)
            $display("** xor_kbucket_routing_table_core: PASSED **");
        else
            $display("** xor_kbucket_routing_table_core: FAILED **");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("** xor_kbucket_routing_table_core: FAILED **");
        $finish;
    end
endmodule
